FILE: design/cdq_pkg.sv
// Shared types and constants of the circular deque engine.
package cdq_pkg;

    localparam int CAP_W  = 5;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_PUSH_BACK  = 2'd1,
        FN_POP_FRONT  = 2'd2,
        FN_POP_BACK   = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic cfg_write;
        logic accept;
        logic load_out;
    } t_dp_cmd;

endpackage

FILE: design/circular_deque_engine.sv
// Top level of the circular deque engine: controller plus datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: i_func picks
//   push front, push back, pop front or pop back, and i_value is the element
//   to push. Output channel (o_out_valid / i_out_stall) returns one result
//   item per input item: o_status (ok, overflow, underflow), o_removed_value
//   (the popped element, zero otherwise) and o_occupancy after the operation.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the capacity;
//   a write clamps it into 1..DEPTH and empties the deque. Write it only
//   while no item is in flight.
// Timing:
//   The accept cycle updates indices and count and issues the slot store
//   access, and the next cycle waits on the registered read port of the slot
//   store. The result register loads at the end of the read cycle once the
//   output register is free. The input stalls during the read cycle, so a new
//   item is taken only after the item in flight has loaded its result.
// Reset:
//   Synchronous, active low. Capacity returns to min(16, DEPTH) and the deque
//   is empty; slot contents are left as they are.
// Stall:
//   A result waiting in the output register does not block the next accept;
//   that item then parks in the read cycle until the output register frees.
module circular_deque_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [cdq_pkg::FUNC_W-1:0]   i_func,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cdq_pkg::STAT_W-1:0]   o_status,
    output logic signed [DATA_WIDTH-1:0] o_removed_value,
    output logic [cdq_pkg::CAP_W-1:0]    o_occupancy,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]    i_cfg_capacity
);
    import cdq_pkg::*;

    t_dp_cmd dp_cmd;
    t_status dp_status;

    // Sequence handshakes and hand commands to the datapath.
    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (dp_cmd)
    );

    // Hold indices, count, slot store and the result register.
    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_cfg_capacity  (i_cfg_capacity),
        .i_func          (i_func),
        .i_value         (i_value),
        .o_status        (dp_status),
        .o_removed_value (o_removed_value),
        .o_occupancy     (o_occupancy)
    );

    assign o_status = dp_status;

    // An accepted item occupies the block for the read cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled in the cycle after an accept");

    // A failed operation never returns an element.
    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_removed_value == '0))
        else $error("removed value nonzero on overflow or underflow");

    // Underflow only happens on an empty deque, which stays empty.
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_UNDERFLOW)) |-> (o_occupancy == '0))
        else $error("underflow reported with nonzero occupancy");

endmodule

FILE: design/cdq_ctrl.sv
// Controller of the circular deque engine: handshakes and sequencing.
module cdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    output cdq_pkg::t_dp_cmd o_cmd
);
    import cdq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_taken;
    logic   accept;
    logic   load;

    assign out_taken = r_out_valid && !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (!r_out_valid || out_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and commands.
    always_comb begin
        accept = 1'b0;
        load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                accept = i_in_valid;
            end
            S_READ: begin
                load = !r_out_valid || out_taken;
            end
            default: begin
                accept = 1'b0;
                load   = 1'b0;
            end
        endcase
        o_in_stall     = (r_state != S_IDLE);
        o_cfg_ready    = (r_state == S_IDLE);
        o_cmd.accept   = accept;
        o_cmd.load_out = load;
        o_cmd.cfg_write = i_cfg_valid && (r_state == S_IDLE);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (out_taken) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: design/cdq_datapath.sv
// Datapath of the circular deque engine: indices, count, slot store, result.
module cdq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cdq_pkg::t_dp_cmd             i_cmd,
    input  logic [cdq_pkg::CAP_W-1:0]    i_cfg_capacity,
    input  logic [cdq_pkg::FUNC_W-1:0]   i_func,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output cdq_pkg::t_status             o_status,
    output logic signed [DATA_WIDTH-1:0] o_removed_value,
    output logic [cdq_pkg::CAP_W-1:0]    o_occupancy
);
    import cdq_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int W       = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
    localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic [CAP_W-1:0] r_cap;
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] r_tail;
    logic [CAP_W-1:0] r_count;

    logic [IDX_W-1:0] n_head;
    logic [IDX_W-1:0] n_tail;
    logic [CAP_W-1:0] n_count;
    logic [CAP_W-1:0] cap_clamped;

    t_status          r_pend_status;
    t_status          n_pend_status;
    logic             r_pend_pop;
    logic             n_pend_pop;
    logic [CAP_W-1:0] r_pend_occ;

    t_status               r_status;
    logic [DATA_WIDTH-1:0] r_removed;
    logic [CAP_W-1:0]      r_occ;

    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] head_prev;
    logic [IDX_W-1:0] tail_next;
    logic [IDX_W-1:0] tail_prev;
    logic [W-1:0]     head_inc;
    logic [W-1:0]     tail_inc;
    logic [W-1:0]     cap_ext;
    logic             full;
    logic             empty;

    assign cap_ext  = W'(r_cap);
    assign head_inc = W'(r_head) + W'(1);
    assign tail_inc = W'(r_tail) + W'(1);
    assign head_next = (head_inc >= cap_ext) ? '0 : IDX_W'(head_inc);
    assign tail_next = (tail_inc >= cap_ext) ? '0 : IDX_W'(tail_inc);
    assign head_prev = (r_head == '0) ? IDX_W'(cap_ext - W'(1)) : r_head - IDX_W'(1);
    assign tail_prev = (r_tail == '0) ? IDX_W'(cap_ext - W'(1)) : r_tail - IDX_W'(1);
    assign full  = (r_count >= r_cap);
    assign empty = (r_count == '0);

    // Clamp a written capacity into 1..DEPTH.
    always_comb begin
        if (i_cfg_capacity == '0) begin
            cap_clamped = CAP_W'(1);
        end else if (W'(i_cfg_capacity) > W'(DEPTH)) begin
            cap_clamped = CAP_W'(DEPTH);
        end else begin
            cap_clamped = i_cfg_capacity;
        end
    end

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_pend_status = ST_OK;
        n_pend_pop    = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        wr_addr       = r_tail;
        rd_addr       = r_head;
        case (t_func'(i_func))
            FN_PUSH_FRONT: begin
                if (full) begin
                    n_pend_status = ST_OVERFLOW;
                end else begin
                    n_head  = head_prev;
                    wr_en   = i_cmd.accept;
                    wr_addr = head_prev;
                    n_count = r_count + CAP_W'(1);
                end
            end
            FN_PUSH_BACK: begin
                if (full) begin
                    n_pend_status = ST_OVERFLOW;
                end else begin
                    n_tail  = tail_next;
                    wr_en   = i_cmd.accept;
                    wr_addr = r_tail;
                    n_count = r_count + CAP_W'(1);
                end
            end
            FN_POP_FRONT: begin
                if (empty) begin
                    n_pend_status = ST_UNDERFLOW;
                end else begin
                    n_head     = head_next;
                    rd_en      = i_cmd.accept;
                    rd_addr    = r_head;
                    n_pend_pop = 1'b1;
                    n_count    = r_count - CAP_W'(1);
                end
            end
            FN_POP_BACK: begin
                if (empty) begin
                    n_pend_status = ST_UNDERFLOW;
                end else begin
                    n_tail     = tail_prev;
                    rd_en      = i_cmd.accept;
                    rd_addr    = tail_prev;
                    n_pend_pop = 1'b1;
                    n_count    = r_count - CAP_W'(1);
                end
            end
            default: begin
                n_pend_status = ST_OK;
            end
        endcase
    end

    // Slot store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_W'(CAP_RST);
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.cfg_write) begin
            r_cap   <= cap_clamped;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Hold the status, pop flag and occupancy of the item in flight until the result register loads them.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_status <= n_pend_status;
            r_pend_pop    <= n_pend_pop;
            r_pend_occ    <= n_count;
        end
        if (i_cmd.load_out) begin
            r_status  <= r_pend_status;
            r_removed <= r_pend_pop ? r_rd_data : '0;
            r_occ     <= r_pend_occ;
        end
    end

    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_occupancy     = r_occ;

endmodule
